// File: rtl/core/i2c_srt_pkg.sv
// ----------------------------------------------------------------------------
// i2c_srt_pkg
// Shared types and constants of the I2C register transfer sequencer.
// ----------------------------------------------------------------------------
package i2c_srt_pkg;

   localparam int MAX_LEN_DEF = 256;   // default saturation / clamp limit
   localparam int LEN_W       = 9;     // transfer_length / byte_count width
   localparam int TX_DEPTH    = 256;   // transmit buffer entries
   localparam int TX_ADDR_W   = 8;
   localparam int BYTE_W      = 8;

   // request opcodes
   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_STATUS = 2'd1,
      OP_LOAD   = 2'd2
   } op_type;

   // controller control codes
   typedef enum logic [2:0] {
      CTL_NONE   = 3'd0,
      CTL_SI     = 3'd1,
      CTL_STO_SI = 3'd2,
      CTL_STA_SI = 3'd3,
      CTL_SI_AA  = 3'd4
   } ctl_type;

   // controller status codes
   localparam logic [7:0] ST_START     = 8'h08;
   localparam logic [7:0] ST_REP_START = 8'h10;
   localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
   localparam logic [7:0] ST_DATA_ACK  = 8'h28;
   localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
   localparam logic [7:0] ST_RX_ACK    = 8'h50;
   localparam logic [7:0] ST_RX_NACK   = 8'h58;

   localparam logic RD_BIT = 1'b1;    // SLA+R direction bit

   typedef struct packed {
      logic [1:0]        opcode;
      logic [6:0]        slave_address;
      logic [7:0]        register_address;
      logic              read_not_write;
      logic [LEN_W-1:0]  transfer_length;
      logic [7:0]        status_code;
      logic [7:0]        received_byte;
      logic [7:0]        buffer_index;
      logic [7:0]        load_byte;
   } item_type;

   typedef struct packed {
      ctl_type           control_code;
      logic              data_write_valid;
      logic [7:0]        data_out;
      logic              rx_valid;
      logic [7:0]        rx_byte;
      logic [LEN_W-1:0]  byte_count;
      logic              done_res;
      logic              error;
   } result_type;

   // transmit buffer port control from the sequencer
   typedef struct packed {
      logic                 wr_en;
      logic [TX_ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0]    wr_data;
      logic [TX_ADDR_W-1:0] rd_addr;
   } buf_ctl_type;

endpackage

// File: rtl/core/i2c_srt_ram.sv
// ----------------------------------------------------------------------------
// i2c_srt_ram
// Generic single write port RAM with one registered read port (read-first).
// ----------------------------------------------------------------------------
module i2c_srt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: rtl/core/i2c_srt_seq.sv
// ----------------------------------------------------------------------------
// i2c_srt_seq
// Transfer state and status decode: one request evaluated per take.
// ----------------------------------------------------------------------------
module i2c_srt_seq import i2c_srt_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  item_type          item,
   input  logic [BYTE_W-1:0] tx_byte,
   output logic              has_result,
   output result_type        result,
   output buf_ctl_type       buf_ctl
);

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam logic [CMP_W:0] MAX_C = (CMP_W + 1)'(MAX_LEN);

   logic             active_ff, active_in;
   logic             reading_ff, reading_in;
   logic [6:0]       addr_ff, addr_in;
   logic [7:0]       reg_ff, reg_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   ctl_type          last_ff, last_in;

   logic [CMP_W:0]   req_len_ext, len_clamp, len_ext, cnt_ext, cnt_inc;
   logic [CMP_W-1:0] rd_ext;

   assign req_len_ext = (CMP_W + 1)'(item.transfer_length);
   assign len_clamp   = (req_len_ext > MAX_C) ? MAX_C : req_len_ext;
   assign len_ext     = (CMP_W + 1)'(len_ff);
   assign cnt_ext     = (CMP_W + 1)'(cnt_ff);
   assign cnt_inc     = (cnt_ext < MAX_C) ? cnt_ext + 1'b1 : cnt_ext;

   always_comb begin
      active_in  = active_ff;
      reading_in = reading_ff;
      addr_in    = addr_ff;
      reg_in     = reg_ff;
      len_in     = len_ff;
      cnt_in     = cnt_ff;
      last_in    = last_ff;
      has_result = 1'b0;
      result     = '0;
      result.control_code = last_ff;
      buf_ctl.wr_en   = 1'b0;
      buf_ctl.wr_addr = item.buffer_index;
      buf_ctl.wr_data = item.load_byte;

      case (item.opcode)
         OP_LOAD: begin
            buf_ctl.wr_en = take;
         end
         OP_START: begin
            has_result = 1'b1;
            active_in  = 1'b1;
            reading_in = item.read_not_write;
            addr_in    = item.slave_address;
            reg_in     = item.register_address;
            len_in     = CNT_W'(len_clamp);
            cnt_in     = '0;
            last_in    = CTL_NONE;
            result.control_code = CTL_STA_SI;
         end
         OP_STATUS: begin
            if (active_ff) begin
               has_result = 1'b1;
               case (item.status_code)
                  ST_START: begin
                     result.data_write_valid = 1'b1;
                     result.data_out         = {addr_ff, 1'b0};
                     result.control_code     = CTL_SI;
                  end
                  ST_SLAW_ACK: begin
                     result.data_write_valid = 1'b1;
                     result.data_out         = reg_ff;
                  end
                  ST_DATA_ACK: begin
                     if (reading_ff) begin
                        result.control_code = CTL_STA_SI;
                     end else if (cnt_ext < len_ext) begin
                        result.data_write_valid = 1'b1;
                        result.data_out         = tx_byte;
                        cnt_in                  = CNT_W'(cnt_inc);
                     end else begin
                        result.control_code = CTL_STO_SI;
                        result.done_res     = 1'b1;
                     end
                  end
                  ST_REP_START: begin
                     if (reading_ff) begin
                        result.data_write_valid = 1'b1;
                        result.data_out         = {addr_ff, RD_BIT};
                        result.control_code     = CTL_SI;
                     end else begin
                        result.control_code = CTL_STO_SI;
                        result.error        = 1'b1;
                     end
                  end
                  ST_SLAR_ACK: begin
                     if (reading_ff) begin
                        result.control_code = (len_ext > (CMP_W + 1)'(1)) ? CTL_SI_AA : CTL_SI;
                     end else begin
                        result.control_code = CTL_STO_SI;
                        result.error        = 1'b1;
                     end
                  end
                  ST_RX_ACK: begin
                     if (reading_ff) begin
                        result.rx_valid     = 1'b1;
                        result.rx_byte      = item.received_byte;
                        cnt_in              = CNT_W'(cnt_inc);
                        result.control_code = ((cnt_inc + 1'b1) < len_ext) ? CTL_SI_AA : CTL_SI;
                     end else begin
                        result.control_code = CTL_STO_SI;
                        result.error        = 1'b1;
                     end
                  end
                  ST_RX_NACK: begin
                     if (reading_ff) begin
                        result.rx_valid     = 1'b1;
                        result.rx_byte      = item.received_byte;
                        cnt_in              = CNT_W'(cnt_inc);
                        result.control_code = CTL_STO_SI;
                        result.done_res     = 1'b1;
                     end else begin
                        result.control_code = CTL_STO_SI;
                        result.error        = 1'b1;
                     end
                  end
                  default: begin
                     // NACK, arbitration loss, bus error or unknown code
                     result.control_code = CTL_STO_SI;
                     result.error        = 1'b1;
                  end
               endcase
               last_in = result.control_code;
               if (result.done_res || result.error) begin
                  active_in = 1'b0;
               end
            end
         end
         default: ;
      endcase

      result.byte_count = LEN_W'(cnt_in);

      // Buffer read is addressed ahead, at the count the next request will see.
      rd_ext          = reset ? '0 : CMP_W'(take ? cnt_in : cnt_ff);
      buf_ctl.rd_addr = rd_ext[TX_ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         reading_ff <= 1'b0;
         addr_ff    <= '0;
         reg_ff     <= '0;
         len_ff     <= '0;
         cnt_ff     <= '0;
         last_ff    <= CTL_NONE;
      end else if (take) begin
         active_ff  <= active_in;
         reading_ff <= reading_in;
         addr_ff    <= addr_in;
         reg_ff     <= reg_in;
         len_ff     <= len_in;
         cnt_ff     <= cnt_in;
         last_ff    <= last_in;
      end
   end

endmodule

// File: rtl/core/i2c_status_register_transfer_top.sv
// ----------------------------------------------------------------------------
// i2c_status_register_transfer_top
// A request is held in the input register, and its result in the result register.
// Throughput: one request per cycle; a stalled result holds req_ready low only
//   once a second request is waiting behind it in the input register.
// Reset: synchronous, active high; clears the transfer state, the input and result
//   valid flags and the bypass flag. The transmit buffer is not cleared and reads undefined until loaded.
// ----------------------------------------------------------------------------
module i2c_status_register_transfer_top import i2c_srt_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_opcode,
   input  logic [6:0]       req_slave_address,
   input  logic [7:0]       req_register_address,
   input  logic             req_read_not_write,
   input  logic [LEN_W-1:0] req_transfer_length,
   input  logic [7:0]       req_status_code,
   input  logic [7:0]       req_received_byte,
   input  logic [7:0]       req_buffer_index,
   input  logic [7:0]       req_load_byte,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_control_code,
   output logic             rsp_data_write_valid,
   output logic [7:0]       rsp_data_out,
   output logic             rsp_rx_valid,
   output logic [7:0]       rsp_rx_byte,
   output logic [LEN_W-1:0] rsp_byte_count,
   output logic             rsp_done_res,
   output logic             rsp_error
);

   // input register
   logic       in_valid_ff;
   item_type   item_ff;
   // result register
   logic       rsp_valid_ff;
   result_type rsp_ff;

   logic        advance;       // request in the input register is evaluated
   logic        has_result;
   result_type  result;
   buf_ctl_type buf_ctl;

   logic [BYTE_W-1:0] ram_rd_data, tx_byte;
   logic              byp_valid_ff;
   logic [BYTE_W-1:0] byp_data_ff;

   // A request moves on when the result register is free or being drained;
   // requests without a result simply empty it.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.opcode           <= req_opcode;
         item_ff.slave_address    <= req_slave_address;
         item_ff.register_address <= req_register_address;
         item_ff.read_not_write   <= req_read_not_write;
         item_ff.transfer_length  <= req_transfer_length;
         item_ff.status_code      <= req_status_code;
         item_ff.received_byte    <= req_received_byte;
         item_ff.buffer_index     <= req_buffer_index;
         item_ff.load_byte        <= req_load_byte;
      end
   end

   i2c_srt_seq #(
      .MAX_LEN (MAX_LEN)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .take       (advance),
      .item       (item_ff),
      .tx_byte    (tx_byte),
      .has_result (has_result),
      .result     (result),
      .buf_ctl    (buf_ctl)
   );

   // Transmit buffer. Read address tracks the upcoming byte count every cycle.
   i2c_srt_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TX_DEPTH)
   ) u_tx_buf (
      .clock   (clock),
      .wr_en   (buf_ctl.wr_en),
      .wr_addr (buf_ctl.wr_addr),
      .wr_data (buf_ctl.wr_data),
      .rd_addr (buf_ctl.rd_addr),
      .rd_data (ram_rd_data)
   );

   // Read-first RAM: a load to the entry being read in the same cycle is
   // forwarded from here.
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b0;
      end else begin
         byp_valid_ff <= buf_ctl.wr_en && (buf_ctl.wr_addr == buf_ctl.rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= buf_ctl.wr_data;
   end

   assign tx_byte = byp_valid_ff ? byp_data_ff : ram_rd_data;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= has_result;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_control_code     = rsp_ff.control_code;
   assign rsp_data_write_valid = rsp_ff.data_write_valid;
   assign rsp_data_out         = rsp_ff.data_out;
   assign rsp_rx_valid         = rsp_ff.rx_valid;
   assign rsp_rx_byte          = rsp_ff.rx_byte;
   assign rsp_byte_count       = rsp_ff.byte_count;
   assign rsp_done_res         = rsp_ff.done_res;
   assign rsp_error            = rsp_ff.error;

endmodule

// File: rtl/core/i2c_srt_checker.sv
// ----------------------------------------------------------------------------
// i2c_srt_checker
// Port-level assertions for the I2C register transfer sequencer.
// ----------------------------------------------------------------------------
module i2c_srt_checker import i2c_srt_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_control_code,
   input logic       rsp_data_write_valid,
   input logic [7:0] rsp_data_out,
   input logic       rsp_rx_valid,
   input logic       rsp_done_res,
   input logic       rsp_error
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_control_code)
         && $stable(rsp_data_out))
      else $error("result changed while stalled");

   a_end_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_done_res && rsp_error))
      else $error("done and error together");

   a_end_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_done_res || rsp_error) |-> rsp_control_code == CTL_STO_SI)
      else $error("transfer end without stop");

   a_dir_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rx_valid |-> !rsp_data_write_valid)
      else $error("receive and write in one result");

   a_dout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data_write_valid |-> rsp_data_out == 8'h00)
      else $error("data_out not zero without write");

endmodule

bind i2c_status_register_transfer_top i2c_srt_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_control_code     (rsp_control_code),
   .rsp_data_write_valid (rsp_data_write_valid),
   .rsp_data_out         (rsp_data_out),
   .rsp_rx_valid         (rsp_rx_valid),
   .rsp_done_res         (rsp_done_res),
   .rsp_error            (rsp_error)
);
